// ===== rtl/set_assoc_lru_miss_counter_assert.svh =====
// Assertion helpers for the cache tag model; expect clk and rst in scope.
`ifndef SET_ASSOC_LRU_MISS_COUNTER_ASSERT_SVH
`define SET_ASSOC_LRU_MISS_COUNTER_ASSERT_SVH

// Same-cycle implication.
`define SALMC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SALMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/salmc_pkg.sv =====
package salmc_pkg;

  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 32;

  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

endpackage

// ===== rtl/salmc_req_if.sv =====
interface salmc_req_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [salmc_pkg::ADDR_W-1:0] byte_address;

  modport source (output valid, output action, output byte_address, input ready);
  modport sink (input valid, input action, input byte_address, output ready);
endinterface

// ===== rtl/salmc_rsp_if.sv =====
interface salmc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [salmc_pkg::COUNT_W-1:0] miss_total;

  modport source (output valid, output hit, output miss_total, input ready);
  modport sink (input valid, input hit, input miss_total, output ready);
endinterface

// ===== rtl/set_assoc_lru_miss_counter.sv =====
// Tag-only set-associative cache with true LRU replacement and a miss counter.
// req channel: action (access or clear) and byte_address, valid/ready.
// rsp channel: hit and miss_total, one transfer per accepted request.
// LINE_SIZE and NUM_SETS must be powers of two; NUM_WAYS is 1 to 16.
// Each set has one row in a tag memory and one in a valid/rank memory,
// both read into registers at request accept.
// A request is registered at accept, its response then in the output register.
// Throughput: one access per cycle while rsp does not stall; a write to the
// set just read is forwarded to the following access, so back-to-back hits to one set work.
// A clear responds with hit low and miss_total zero, then sweeps the
// valid/rank memory one set per cycle: req.ready stays low from the
// clear's transfer until the sweep ends.
// Reset starts the same sweep; req.ready rises when it ends.
// The response sits in an output register; while rsp.ready is low one more
// request can still be read and held, then req.ready drops until the
// response transfer frees the register.
module set_assoc_lru_miss_counter #(
  parameter int LINE_SIZE  = 64,
  parameter int NUM_SETS   = 16,
  parameter int NUM_WAYS   = 4
) (
  input  logic               clk,
  input  logic               rst,
  salmc_req_if.sink          req,
  salmc_rsp_if.source        rsp
);

  localparam int LOG_LINE = $clog2(LINE_SIZE);
  localparam int LOG_SETS = $clog2(NUM_SETS);
  localparam int SET_W    = (LOG_SETS > 0) ? LOG_SETS : 1;
  localparam int TAG_W    = salmc_pkg::ADDR_W - LOG_LINE - LOG_SETS;
  localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int RANK_W   = WAY_W;
  localparam logic [salmc_pkg::ADDR_W-1:0] SET_MASK = salmc_pkg::ADDR_W'(NUM_SETS - 1);
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(NUM_WAYS - 1);
  localparam logic [SET_W-1:0]  SET_LAST = SET_W'(NUM_SETS - 1);

  typedef struct packed {
    logic [NUM_WAYS-1:0]             vld;
    logic [NUM_WAYS-1:0][RANK_W-1:0] rank;
  } meta_t;

  typedef logic [NUM_WAYS-1:0][TAG_W-1:0] tag_row_t;

  meta_t    meta_mem [NUM_SETS];
  tag_row_t tag_mem  [NUM_SETS];

  meta_t    meta_rd, fwd_meta, meta_cur, meta_new;
  tag_row_t tag_rd, fwd_tag, tag_cur, tag_new;
  logic     fwd;

  logic                         s1_valid, s1_clear;
  logic [SET_W-1:0]             s1_set;
  logic [TAG_W-1:0]             s1_tag;
  logic                         rsp_valid;
  logic [salmc_pkg::COUNT_W-1:0] miss_count, cnt_inc;
  logic                         clearing;
  logic [SET_W-1:0]             clr_idx;

  logic [salmc_pkg::ADDR_W-1:0] in_line;
  logic [SET_W-1:0]             in_set;
  logic [TAG_W-1:0]             in_tag;
  logic                         in_ready, in_fire, s1_fire, s1_wr;

  logic [NUM_WAYS-1:0] hit_vec;
  logic                hit_any, free_any;
  logic [WAY_W-1:0]    hit_way, free_way, old_way, sel_way;
  logic [RANK_W-1:0]   limit;

  assign in_line  = req.byte_address >> LOG_LINE;
  assign in_set   = SET_W'(in_line & SET_MASK);
  assign in_tag   = TAG_W'(in_line >> LOG_SETS);

  assign s1_fire  = s1_valid && (!rsp_valid || rsp.ready);
  assign s1_wr    = s1_fire && !s1_clear;
  assign in_ready = !clearing && (!s1_valid || (s1_fire && !s1_clear));
  assign in_fire  = req.valid && in_ready;
  assign req.ready = in_ready;

  assign meta_cur = fwd ? fwd_meta : meta_rd;
  assign tag_cur  = fwd ? fwd_tag : tag_rd;
  assign cnt_inc  = (miss_count == '1) ? miss_count : miss_count + 1'b1;

  always_comb begin
    hit_vec  = '0;
    hit_way  = '0;
    free_way = '0;
    old_way  = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      hit_vec[w] = meta_cur.vld[w] && (tag_cur[w] == s1_tag);
    end
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = WAY_W'(w);
      if (!meta_cur.vld[w]) free_way = WAY_W'(w);
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (meta_cur.rank[w] == RANK_MAX) old_way = WAY_W'(w);
    end
    hit_any  = |hit_vec;
    free_any = !(&meta_cur.vld);
    sel_way  = hit_any ? hit_way : (free_any ? free_way : old_way);
    limit    = meta_cur.rank[hit_way];

    meta_new = meta_cur;
    tag_new  = tag_cur;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (WAY_W'(w) != sel_way && meta_cur.vld[w] &&
          (!hit_any || meta_cur.rank[w] < limit)) begin
        meta_new.rank[w] = meta_cur.rank[w] + 1'b1;
      end
    end
    meta_new.rank[sel_way] = '0;
    meta_new.vld[sel_way]  = 1'b1;
    if (!hit_any) tag_new[sel_way] = s1_tag;
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      meta_mem[clr_idx] <= '0;
    end else if (s1_wr) begin
      meta_mem[s1_set] <= meta_new;
    end
    if (s1_wr) begin
      tag_mem[s1_set] <= tag_new;
    end
    if (in_fire) begin
      meta_rd  <= meta_mem[in_set];
      tag_rd   <= tag_mem[in_set];
      fwd_meta <= meta_new;
      fwd_tag  <= tag_new;
      s1_clear <= (req.action == salmc_pkg::ACT_CLEAR);
      s1_set   <= in_set;
      s1_tag   <= in_tag;
    end
    if (s1_fire) begin
      if (s1_clear) begin
        rsp.hit        <= 1'b0;
        rsp.miss_total <= '0;
      end else begin
        rsp.hit        <= hit_any;
        rsp.miss_total <= hit_any ? miss_count : cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      rsp_valid  <= 1'b0;
      fwd        <= 1'b0;
      miss_count <= '0;
      clearing   <= 1'b1;
      clr_idx    <= '0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
        fwd      <= s1_wr && (s1_set == in_set);
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (s1_fire && s1_clear) begin
        miss_count <= '0;
      end else if (s1_wr && !hit_any) begin
        miss_count <= cnt_inc;
      end
      if (s1_fire && s1_clear) begin
        clearing <= 1'b1;
        clr_idx  <= '0;
      end else if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == SET_LAST) clearing <= 1'b0;
      end
    end
  end

  assign rsp.valid = rsp_valid;

`include "set_assoc_lru_miss_counter_assert.svh"

  `SALMC_ASSERT_SAME(a_no_take_in_sweep, clearing, !in_ready, "request taken during sweep")
  `SALMC_ASSERT_SAME(a_one_way_hits, s1_valid && !s1_clear, $onehot0(hit_vec), "tag in two ways")
  `SALMC_ASSERT_NEXT(a_hit_keeps_count, s1_wr && hit_any, $stable(miss_count), "hit moved count")
  `SALMC_ASSERT_NEXT(a_count_no_drop, !(s1_fire && s1_clear),
                     miss_count >= $past(miss_count), "miss count dropped without clear")
  `SALMC_ASSERT_NEXT(a_rsp_after_done, s1_fire, rsp_valid, "finished item left no response")

endmodule
